// ===== src/ray_triangle_intersect_core_macros.svh =====
// Assertion macros shared by the ray/triangle intersection core.
`ifndef RAY_TRIANGLE_INTERSECT_CORE_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RTI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies a property in the next.
`define RTI_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

// ===== src/rti_pkg.sv =====
// Package: shared constants, register codes and sideband types.
package rti_pkg;

  localparam int TOL_W = 16;
  localparam int MUL_LIMB = 32;
  localparam int QD = 2;
  localparam int QAW = $clog2(QD);
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_ORIGIN_Z  = 3'd2,
    CFG_DIR_X     = 3'd3,
    CFG_DIR_Y     = 3'd4,
    CFG_DIR_Z     = 3'd5,
    CFG_TOLERANCE = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic miss;
    logic neg;
    logic ovf;
  } div_tag_t;

endpackage

// ===== src/rti_intf.sv =====
// Interfaces: triangle input channel and intersection result channel.
interface rti_tri_if #(
  parameter int CW = 32
);
  logic valid;
  logic ready;
  logic signed [CW-1:0] vert_a_x;
  logic signed [CW-1:0] vert_a_y;
  logic signed [CW-1:0] vert_a_z;
  logic signed [CW-1:0] vert_b_x;
  logic signed [CW-1:0] vert_b_y;
  logic signed [CW-1:0] vert_b_z;
  logic signed [CW-1:0] vert_c_x;
  logic signed [CW-1:0] vert_c_y;
  logic signed [CW-1:0] vert_c_z;

  modport source (
    output valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
    vert_c_x, vert_c_y, vert_c_z,
    input ready
  );
  modport sink (
    input valid, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
    vert_c_x, vert_c_y, vert_c_z,
    output ready
  );
endinterface

interface rti_res_if #(
  parameter int CW = 32
);
  logic valid;
  logic ready;
  logic hit;
  logic signed [CW-1:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

// ===== src/rti_mul.sv =====
// Two-stage signed multiplier: limb partial products, then shifted sum.
module rti_mul #(
  parameter int WA = 18,
  parameter int WB = 33
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [WA-1:0]   a_i,
  input  logic signed [WB-1:0]   b_i,
  output logic signed [WA+WB-1:0] p_o
);
  import rti_pkg::*;

  localparam int NL = (WB + MUL_LIMB - 1) / MUL_LIMB;
  localparam int BX = NL * MUL_LIMB;
  localparam int PPW = WA + MUL_LIMB + 1;
  localparam int ACCW = WA + BX + 1;

  logic signed [BX-1:0] bx;
  logic signed [MUL_LIMB:0] limb [NL];
  logic signed [PPW-1:0] pp_d [NL];
  logic signed [PPW-1:0] pp_q [NL];
  logic signed [ACCW-1:0] acc;
  logic signed [WA+WB-1:0] p_q;

  always_comb begin
    bx = BX'(b_i);
    for (int k = 0; k < NL; k++) begin
      if (k == NL - 1) begin
        limb[k] = {bx[k*MUL_LIMB+MUL_LIMB-1], bx[k*MUL_LIMB +: MUL_LIMB]};
      end else begin
        limb[k] = {1'b0, bx[k*MUL_LIMB +: MUL_LIMB]};
      end
      pp_d[k] = a_i * limb[k];
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NL; k++) begin
      acc = acc + (ACCW'(pp_q[k]) <<< (k * MUL_LIMB));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q <= pp_d;
      p_q  <= (WA+WB)'(acc);
    end
  end

  assign p_o = p_q;

endmodule

// ===== src/rti_div.sv =====
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
module rti_div #(
  parameter int CW = 32,
  parameter int NW = 118,
  parameter int PW = 102
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [NW-1:0]       num_i,
  input  logic [PW-1:0]       den_i,
  input  rti_pkg::div_tag_t   tag_i,
  output logic [CW-1:0]       quo_o,
  output rti_pkg::div_tag_t   tag_o
);
  import rti_pkg::*;

  localparam int RW = ((NW > PW + CW) ? NW : PW + CW) + 1;

  logic [RW-1:0] rem_q [CW+1];
  logic [PW-1:0] den_q [CW+1];
  logic [CW-1:0] quo_q [CW+1];
  div_tag_t      tag_q [CW+1];
  logic [RW-1:0] lim0;
  div_tag_t      tag0;

  always_comb begin
    lim0 = RW'(den_i) << CW;
    tag0 = tag_i;
    tag0.ovf = (RW'(num_i) >= lim0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      tag_q[0] <= tag0;
    end
  end

  for (genvar g = 1; g <= CW; g++) begin : g_bit
    localparam int K = CW - g;
    logic [RW-1:0] dsh;
    logic [RW:0]   trial;

    always_comb begin
      dsh   = RW'(den_q[g-1]) << K;
      trial = {1'b0, rem_q[g-1]} - {1'b0, dsh};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= trial[RW] ? rem_q[g-1] : trial[RW-1:0];
        quo_q[g] <= quo_q[g-1] | (CW'(!trial[RW]) << K);
        den_q[g] <= den_q[g-1];
        tag_q[g] <= tag_q[g-1];
      end
    end
  end

  assign quo_o = quo_q[CW];
  assign tag_o = tag_q[CW];

endmodule

// ===== src/rti_front.sv =====
// Front end: take triangles, form edges and origin offset, hold them in a short queue.
module rti_front #(
  parameter int CW = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rti_tri_if.sink             tri_i,
  input  logic signed [CW-1:0] origin_x_i,
  input  logic signed [CW-1:0] origin_y_i,
  input  logic signed [CW-1:0] origin_z_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output logic signed [CW:0]  e1_o [3],
  output logic signed [CW:0]  e2_o [3],
  output logic signed [CW:0]  s_o [3]
);
  import rti_pkg::*;

  localparam int EW = CW + 1;
  localparam int ENT_W = 9 * EW;

  logic [ENT_W-1:0] mem_q [QD];
  logic [QAW-1:0]   wr_ptr_q;
  logic [QAW-1:0]   rd_ptr_q;
  logic [QAW:0]     cnt_q;
  logic [QAW:0]     cnt_d;
  logic             push;
  logic [ENT_W-1:0] ent_d;
  logic [ENT_W-1:0] ent;
  logic signed [EW-1:0] va [3];
  logic signed [EW-1:0] vb [3];
  logic signed [EW-1:0] vc [3];
  logic signed [EW-1:0] org [3];

  always_comb begin
    va[0]  = EW'(tri_i.vert_a_x);
    va[1]  = EW'(tri_i.vert_a_y);
    va[2]  = EW'(tri_i.vert_a_z);
    vb[0]  = EW'(tri_i.vert_b_x);
    vb[1]  = EW'(tri_i.vert_b_y);
    vb[2]  = EW'(tri_i.vert_b_z);
    vc[0]  = EW'(tri_i.vert_c_x);
    vc[1]  = EW'(tri_i.vert_c_y);
    vc[2]  = EW'(tri_i.vert_c_z);
    org[0] = EW'(origin_x_i);
    org[1] = EW'(origin_y_i);
    org[2] = EW'(origin_z_i);
    for (int i = 0; i < 3; i++) begin
      ent_d[i*EW +: EW]     = vb[i] - va[i];
      ent_d[(3+i)*EW +: EW] = vc[i] - va[i];
      ent_d[(6+i)*EW +: EW] = org[i] - va[i];
    end
  end

  assign tri_i.ready = (cnt_q != (QAW+1)'(QD));
  assign push = tri_i.valid && tri_i.ready;
  assign cnt_d = cnt_q + (QAW+1)'(push) - (QAW+1)'(q_pop_i);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= ent_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign ent = mem_q[rd_ptr_q];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_o[i] = $signed(ent[i*EW +: EW]);
      e2_o[i] = $signed(ent[(3+i)*EW +: EW]);
      s_o[i]  = $signed(ent[(6+i)*EW +: EW]);
    end
  end

endmodule

// ===== src/rti_back.sv =====
// Back end: cross and dot products, tests, distance divide and result register.
`include "ray_triangle_intersect_core_macros.svh"

module rti_back #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [FB+1:0]          dir_x_i,
  input  logic signed [FB+1:0]          dir_y_i,
  input  logic signed [FB+1:0]          dir_z_i,
  input  logic [rti_pkg::TOL_W-1:0]     tol_i,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  logic signed [CW:0]            e1_i [3],
  input  logic signed [CW:0]            e2_i [3],
  input  logic signed [CW:0]            s_i [3],
  rti_res_if.source                     res_o
);
  import rti_pkg::*;

  localparam int DW = FB + 2;
  localparam int EW = CW + 1;
  localparam int PDE = DW + EW;
  localparam int HW = PDE + 1;
  localparam int PSE = 2 * EW;
  localparam int QW = PSE + 1;
  localparam int PEH = EW + HW;
  localparam int PDQ = DW + QW;
  localparam int PEQ = EW + QW;
  localparam int PM1 = (PEH > PDQ) ? PEH : PDQ;
  localparam int PMX = (PM1 > PEQ) ? PM1 : PEQ;
  localparam int PW = PMX + 2;
  localparam int NW = PW + FB;
  localparam int TW = TOL_W + 2 * FB;
  localparam int CMPW = ((PW + 1 > TW) ? PW + 1 : TW) + 1;
  localparam int NV = CW + 10;
  localparam int LAST = NV - 1;

  logic [NV-1:0] vld_q;
  logic          en;
  logic signed [DW-1:0] d [3];

  logic signed [EW-1:0] e1_p_q [3][3];
  logic signed [EW-1:0] e2_p_q [3][3];
  logic signed [EW-1:0] s_p_q  [3][3];

  logic signed [PDE-1:0] hp [3];
  logic signed [PDE-1:0] hn [3];
  logic signed [PSE-1:0] qp [3];
  logic signed [PSE-1:0] qn [3];
  logic signed [HW-1:0]  h_q [3];
  logic signed [QW-1:0]  q_q [3];

  logic signed [PEH-1:0] pdet [3];
  logic signed [PEH-1:0] psu [3];
  logic signed [PDQ-1:0] psv [3];
  logic signed [PEQ-1:0] pst [3];

  logic signed [PW-1:0] det_q, su_q, sv_q, st_q;
  logic signed [PW-1:0] detn_q, sun_q, svn_q, stn_q;
  logic                 flip;

  logic [CMPW-1:0]      thr;
  logic [CMPW-1:0]      detz;
  logic signed [PW:0]   uv;
  logic [PW-1:0]        st_abs;
  logic [NW-1:0]        num_q;
  logic [PW-1:0]        den_q;
  div_tag_t             tag_d, tag_q, tag_div;
  logic [CW-1:0]        quo;

  logic [CW-1:0]        lim, mag;
  logic                 hit_d, hit_q;
  logic signed [CW-1:0] dist_d, dist_q;

  assign en = !vld_q[LAST] || res_o.ready;
  assign q_pop_o = en && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], q_valid_i};
    end
  end

  always_comb begin
    d[0] = dir_x_i;
    d[1] = dir_y_i;
    d[2] = dir_z_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_p_q[0][i] <= e1_i[i];
        e2_p_q[0][i] <= e2_i[i];
        s_p_q[0][i]  <= s_i[i];
        for (int k = 1; k < 3; k++) begin
          e1_p_q[k][i] <= e1_p_q[k-1][i];
          e2_p_q[k][i] <= e2_p_q[k-1][i];
          s_p_q[k][i]  <= s_p_q[k-1][i];
        end
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    rti_mul #(.WA(DW), .WB(EW)) u_hp (
      .clk_i, .en_i(en), .a_i(d[J]), .b_i(e2_i[K]), .p_o(hp[i])
    );
    rti_mul #(.WA(DW), .WB(EW)) u_hn (
      .clk_i, .en_i(en), .a_i(d[K]), .b_i(e2_i[J]), .p_o(hn[i])
    );
    rti_mul #(.WA(EW), .WB(EW)) u_qp (
      .clk_i, .en_i(en), .a_i(s_i[J]), .b_i(e1_i[K]), .p_o(qp[i])
    );
    rti_mul #(.WA(EW), .WB(EW)) u_qn (
      .clk_i, .en_i(en), .a_i(s_i[K]), .b_i(e1_i[J]), .p_o(qn[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        h_q[i] <= HW'(hp[i]) - HW'(hn[i]);
        q_q[i] <= QW'(qp[i]) - QW'(qn[i]);
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_dot
    rti_mul #(.WA(EW), .WB(HW)) u_det (
      .clk_i, .en_i(en), .a_i(e1_p_q[2][i]), .b_i(h_q[i]), .p_o(pdet[i])
    );
    rti_mul #(.WA(EW), .WB(HW)) u_su (
      .clk_i, .en_i(en), .a_i(s_p_q[2][i]), .b_i(h_q[i]), .p_o(psu[i])
    );
    rti_mul #(.WA(DW), .WB(QW)) u_sv (
      .clk_i, .en_i(en), .a_i(d[i]), .b_i(q_q[i]), .p_o(psv[i])
    );
    rti_mul #(.WA(EW), .WB(QW)) u_st (
      .clk_i, .en_i(en), .a_i(e2_p_q[2][i]), .b_i(q_q[i]), .p_o(pst[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= PW'(pdet[0]) + PW'(pdet[1]) + PW'(pdet[2]);
      su_q  <= PW'(psu[0]) + PW'(psu[1]) + PW'(psu[2]);
      sv_q  <= PW'(psv[0]) + PW'(psv[1]) + PW'(psv[2]);
      st_q  <= PW'(pst[0]) + PW'(pst[1]) + PW'(pst[2]);
    end
  end

  assign flip = det_q[PW-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      detn_q <= flip ? -det_q : det_q;
      sun_q  <= flip ? -su_q : su_q;
      svn_q  <= flip ? -sv_q : sv_q;
      stn_q  <= flip ? -st_q : st_q;
    end
  end

  always_comb begin
    thr    = CMPW'(tol_i) << (2 * FB);
    detz   = CMPW'($unsigned(detn_q));
    uv     = (PW+1)'(sun_q) + (PW+1)'(svn_q);
    st_abs = stn_q[PW-1] ? $unsigned(-stn_q) : $unsigned(stn_q);
    tag_d.miss = (detz <= thr) || sun_q[PW-1] || (sun_q > detn_q) ||
                 svn_q[PW-1] || (uv > (PW+1)'(detn_q));
    tag_d.neg  = stn_q[PW-1];
    tag_d.ovf  = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= {st_abs, {FB{1'b0}}};
      den_q <= $unsigned(detn_q);
      tag_q <= tag_d;
    end
  end

  rti_div #(.CW(CW), .NW(NW), .PW(PW)) u_div (
    .clk_i,
    .en_i  (en),
    .num_i (num_q),
    .den_i (den_q),
    .tag_i (tag_q),
    .quo_o (quo),
    .tag_o (tag_div)
  );

  always_comb begin
    lim    = tag_div.neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    mag    = (tag_div.ovf || (quo > lim)) ? lim : quo;
    hit_d  = !tag_div.miss && (mag > CW'(tol_i));
    dist_d = '0;
    if (hit_d) begin
      dist_d = tag_div.neg ? -$signed(mag) : $signed(mag);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  assign res_o.valid    = vld_q[LAST];
  assign res_o.hit      = hit_q;
  assign res_o.distance = dist_q;

  `RTI_ASSERT(a_miss_dist_zero, (vld_q[LAST] && !hit_q) |-> (dist_q == '0), "miss with distance")
  `RTI_ASSERT(a_hit_dist_nonzero, (vld_q[LAST] && hit_q) |-> (dist_q != '0), "hit at zero")
  `RTI_ASSERT_NEXT(a_stall_hold, vld_q[LAST] && !res_o.ready, $stable(vld_q), "pipe moved in stall")

endmodule

// ===== src/ray_triangle_intersect_core.sv =====
// Top level: ray/triangle intersection core with ray configuration registers.
// Throughput: one triangle per cycle while results are taken.
// The divider produces one quotient bit per pipeline stage.
// Reset: origin 0, direction (0, 0, 1.0), tolerance one LSB; queue and pipeline empty.
module ray_triangle_intersect_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16,
  localparam int CW1 = (COORD_WIDTH > FRAC_BITS + 2) ? COORD_WIDTH : FRAC_BITS + 2,
  localparam int CFG_W = (CW1 > rti_pkg::TOL_W) ? CW1 : rti_pkg::TOL_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rti_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  rti_tri_if.sink                        tri_i,
  rti_res_if.source                      res_o
);
  import rti_pkg::*;

  localparam int DW = FRAC_BITS + 2;
  localparam int EW = COORD_WIDTH + 1;

  logic signed [COORD_WIDTH-1:0] origin_x_q, origin_y_q, origin_z_q;
  logic signed [DW-1:0]          dir_x_q, dir_y_q, dir_z_q;
  logic [TOL_W-1:0]              tol_q;

  logic                 q_valid;
  logic                 q_pop;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [EW-1:0] s [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      dir_x_q    <= '0;
      dir_y_q    <= '0;
      dir_z_q    <= DW'(1) << FRAC_BITS;
      tol_q      <= TOL_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X:  origin_x_q <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        CFG_ORIGIN_Y:  origin_y_q <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        CFG_ORIGIN_Z:  origin_z_q <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        CFG_DIR_X:     dir_x_q    <= $signed(cfg_data_i[DW-1:0]);
        CFG_DIR_Y:     dir_y_q    <= $signed(cfg_data_i[DW-1:0]);
        CFG_DIR_Z:     dir_z_q    <= $signed(cfg_data_i[DW-1:0]);
        CFG_TOLERANCE: tol_q      <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  rti_front #(.CW(COORD_WIDTH)) u_front (
    .clk_i,
    .rst_ni,
    .tri_i      (tri_i),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .origin_z_i (origin_z_q),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .e1_o       (e1),
    .e2_o       (e2),
    .s_o        (s)
  );

  rti_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .dir_x_i   (dir_x_q),
    .dir_y_i   (dir_y_q),
    .dir_z_i   (dir_z_q),
    .tol_i     (tol_q),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .e1_i      (e1),
    .e2_i      (e2),
    .s_i       (s),
    .res_o     (res_o)
  );

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the ray/triangle intersection core: random and directed triangles checked against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rti_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int DW = FB + 2;
  localparam int DRAIN = CW + 20;
  localparam int ONE = 1 << FB;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    logic hit;
    coord_t distance;
  } isect_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CW-1:0] cfg_data_i = '0;

  rti_tri_if #(.CW(CW)) tri_bus ();
  rti_res_if #(.CW(CW)) res_bus ();

  ray_triangle_intersect_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .tri_i(tri_bus), .res_o(res_bus)
  );

  always #5 clk_i = ~clk_i;

  coord_t ray_org[3];
  logic signed [DW-1:0] ray_dir[3];
  logic [TOL_W-1:0] ray_tol;
  isect_t pending_isect[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit failed = 0;

  initial begin
    tri_bus.valid = 1'b0;
    tri_bus.vert_a_x = '0; tri_bus.vert_a_y = '0; tri_bus.vert_a_z = '0;
    tri_bus.vert_b_x = '0; tri_bus.vert_b_y = '0; tri_bus.vert_b_z = '0;
    tri_bus.vert_c_x = '0; tri_bus.vert_c_y = '0; tri_bus.vert_c_z = '0;
    res_bus.ready = 1'b0;
  end

  function automatic isect_t predict_isect(coord_t v[9]);
    wide_t e1[3], e2[3], s[3], d[3], h[3], q[3];
    wide_t det, su, sv, st, mag, lim;
    bit neg;
    isect_t r;
    r.hit = 1'b0;
    r.distance = '0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = wide_t'(v[3+i]) - wide_t'(v[i]);
      e2[i] = wide_t'(v[6+i]) - wide_t'(v[i]);
      s[i] = wide_t'(ray_org[i]) - wide_t'(v[i]);
      d[i] = wide_t'(ray_dir[i]);
    end
    h[0] = d[1]*e2[2] - d[2]*e2[1];
    h[1] = d[2]*e2[0] - d[0]*e2[2];
    h[2] = d[0]*e2[1] - d[1]*e2[0];
    q[0] = s[1]*e1[2] - s[2]*e1[1];
    q[1] = s[2]*e1[0] - s[0]*e1[2];
    q[2] = s[0]*e1[1] - s[1]*e1[0];
    det = e1[0]*h[0] + e1[1]*h[1] + e1[2]*h[2];
    su = s[0]*h[0] + s[1]*h[1] + s[2]*h[2];
    sv = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
    st = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    if (det < 0) begin
      det = -det; su = -su; sv = -sv; st = -st;
    end
    if (det <= (wide_t'(ray_tol) <<< (2*FB))) return r;
    if (su < 0 || su > det) return r;
    if (sv < 0 || su + sv > det) return r;
    neg = st < 0;
    if (neg) st = -st;
    mag = (st <<< FB) / det;
    lim = neg ? (wide_t'(1) <<< (CW-1)) : ((wide_t'(1) <<< (CW-1)) - 1);
    if (mag > lim) mag = lim;
    if (mag <= wide_t'(ray_tol)) return r;
    r.hit = 1'b1;
    r.distance = neg ? coord_t'(-mag) : coord_t'(mag);
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    isect_t exp_r;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (pending_isect.size() == 0) begin
        $display("%0t: unexpected result hit=%0b distance=%0d", $time,
                 res_bus.hit, res_bus.distance);
        failed = 1;
      end else begin
        exp_r = pending_isect.pop_front();
        if (res_bus.hit !== exp_r.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, res_bus.hit);
          failed = 1;
        end
        if (res_bus.distance !== exp_r.distance) begin
          $display("%0t: distance expected %0d actual %0d", $time, exp_r.distance,
                   res_bus.distance);
          failed = 1;
        end
      end
    end
  end

  task automatic send_triangle(coord_t v[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      tri_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    tri_bus.valid <= 1'b1;
    tri_bus.vert_a_x <= v[0]; tri_bus.vert_a_y <= v[1]; tri_bus.vert_a_z <= v[2];
    tri_bus.vert_b_x <= v[3]; tri_bus.vert_b_y <= v[4]; tri_bus.vert_b_z <= v[5];
    tri_bus.vert_c_x <= v[6]; tri_bus.vert_c_y <= v[7]; tri_bus.vert_c_z <= v[8];
    do @(posedge clk_i); while (!tri_bus.ready);
    pending_isect.push_back(predict_isect(v));
  endtask

  task automatic drain_results();
    tri_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_isect.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ORIGIN_X: ray_org[0] = data;
      CFG_ORIGIN_Y: ray_org[1] = data;
      CFG_ORIGIN_Z: ray_org[2] = data;
      CFG_DIR_X: ray_dir[0] = data[DW-1:0];
      CFG_DIR_Y: ray_dir[1] = data[DW-1:0];
      CFG_DIR_Z: ray_dir[2] = data[DW-1:0];
      CFG_TOLERANCE: ray_tol = data[TOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_ray(coord_t ox, coord_t oy, coord_t oz, int dx, int dy, int dz,
                         int tol);
    drain_results();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_DIR_X, dx);
    write_reg(CFG_DIR_Y, dy);
    write_reg(CFG_DIR_Z, dz);
    write_reg(CFG_TOLERANCE, tol);
  endtask

  task automatic send_flat(int z, int x0, int y0, int x1, int y1, int x2, int y2);
    coord_t v[9];
    v = '{x0*ONE, y0*ONE, z*ONE, x1*ONE, y1*ONE, z*ONE, x2*ONE, y2*ONE, z*ONE};
    send_triangle(v);
  endtask

  task automatic test_directed();
    coord_t v[9];
    send_flat(5, -1, -1, 2, -1, -1, 2);
    send_flat(5, -1, -1, -1, 2, 2, -1);
    send_flat(-5, -1, -1, 2, -1, -1, 2);
    send_flat(0, -1, -1, 2, -1, -1, 2);
    send_flat(5, 1, 1, 3, 1, 1, 3);
    send_flat(5, 0, 0, 2, 0, 0, 2);
    send_flat(5, -2, 0, 0, 0, 0, 2);
    send_flat(5, 1, -1, 1, 1, -1, 1);
    v = '{default: 32'sh7fffffff};
    send_triangle(v);
    v = '{default: 32'sh80000000};
    send_triangle(v);
    v = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
          32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    send_triangle(v);
    v = '{32'sh80000000, 32'sh80000000, 32'sh00000000, 32'sh7fffffff, 32'sh80000000,
          32'sh00000000, 32'sh80000000, 32'sh7fffffff, 32'sh00000000};
    send_triangle(v);
    v = '{0, 0, 0, ONE, 0, 0, 2*ONE, 0, 0};
    send_triangle(v);
  endtask

  task automatic test_extreme_rays();
    set_ray(0, 0, 32'sh80000000, 0, 0, ONE, 0);
    send_flat(32767, -1, -1, 2, -1, -1, 2);
    send_flat(-32768, -1, -1, 2, -1, -1, 2);
    set_ray(0, 0, 32'sh7fffffff, 0, 0, -ONE, 0);
    send_flat(-32768, -1, -1, 2, -1, -1, 2);
    send_flat(0, -1, -1, 2, -1, -1, 2);
    set_ray(0, 0, 0, 0, 0, ONE, 65535);
    send_flat(5, -1, -1, 2, -1, -1, 2);
    send_flat(300, -200, -200, 400, -200, -200, 400);
    set_ray(32'sh7fffffff, 32'sh80000000, 0, -ONE, ONE, 0, 1);
    send_flat(0, -1, -1, 2, -1, -1, 2);
  endtask

  function automatic coord_t rand_span(int span);
    return $signed($urandom_range(2*span)) - span;
  endfunction

  task automatic test_random(int count);
    coord_t v[9];
    coord_t p[3];
    int t;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        set_ray(rand_span(1 << 20), rand_span(1 << 20), rand_span(1 << 20),
                rand_span(ONE), rand_span(ONE), rand_span(ONE),
                ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(64));
      end
      if ($urandom_range(9) < 2) begin
        foreach (v[i]) v[i] = $urandom;
      end else begin
        t = rand_span(20 * ONE);
        for (int i = 0; i < 3; i++)
          p[i] = ray_org[i] + coord_t'((longint'(t) * ray_dir[i]) >>> FB);
        foreach (v[i]) v[i] = p[i % 3] + rand_span(1 << 18);
      end
      send_triangle(v);
    end
  endtask

  initial begin
    ray_org = '{0, 0, 0};
    ray_dir = '{0, 0, ONE};
    ray_tol = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 19;
    recv_idle_pct = 61;
    test_directed();
    test_extreme_rays();
    test_random(400);
    send_idle_pct = 61;
    recv_idle_pct = 19;
    test_random(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(400);
    drain_results();
    if (!failed) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+src
src/rti_pkg.sv
src/rti_intf.sv
src/rti_mul.sv
src/rti_div.sv
src/rti_front.sv
src/rti_back.sv
src/ray_triangle_intersect_core.sv
sim/tb_top.sv
